// ===== rtl/core/wildcard_rule_priority_matcher_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the wildcard rule priority matcher
// Each macro expands to one labelled concurrent assertion, clocked on clk
// and switched off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef WILDCARD_RULE_PRIORITY_MATCHER_DEFINES_SVH
`define WILDCARD_RULE_PRIORITY_MATCHER_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent
`define WRPM_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent
`define WRPM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/wrpm_pkg.sv =====
// ----------------------------------------------------------------------------
// wrpm_pkg
// Types, codes and helpers shared by the wildcard rule priority matcher.
// ----------------------------------------------------------------------------
package wrpm_pkg;

  // Defaults for the top-level parameters
  localparam int RULE_DEPTH_DEF   = 32;
  localparam int ACTION_WIDTH_DEF = 32;

  // Fixed field widths
  localparam int ACT_FIELD_W = 32;
  localparam int IDX_W       = 5;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 8;

  // Item actions
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_INPUT_BASE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RULE_COUNT = 2'd1;

  // Match kinds
  localparam logic [1:0] KIND_EXACT     = 2'd0;
  localparam logic [1:0] KIND_STATE_WC  = 2'd1;
  localparam logic [1:0] KIND_INPUT_WC  = 2'd2;
  localparam logic [1:0] KIND_CATCH_ALL = 2'd3;

  // Character codes
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7a;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5a;
  localparam logic [7:0] CH_DIGIT_0 = 8'h30;
  localparam logic [7:0] CH_DIGIT_9 = 8'h39;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_CR      = 8'h0d;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [8:0] FOLD_DELTA = 9'd32;

  typedef struct packed {
    logic                   action;
    logic [IDX_W-1:0]       rule_index;
    logic [7:0]             state_value;
    logic                   state_negate;
    logic                   state_any;
    logic [7:0]             input_value;
    logic                   input_negate;
    logic [3:0]             class_mask;
    logic                   input_any;
    logic                   case_fold;
    logic [ACT_FIELD_W-1:0] action_word;
  } in_item_t;

  typedef struct packed {
    logic                   found;
    logic [ACT_FIELD_W-1:0] result_action;
    logic [IDX_W-1:0]       hit_index;
    logic [1:0]             match_kind;
  } out_item_t;

  // Rule fields as held in the table, without the action word
  typedef struct packed {
    logic [7:0] sval;
    logic       sneg;
    logic       sany;
    logic [7:0] ival;
    logic       ineg;
    logic [3:0] cls;
    logic       iany;
    logic       fold;
  } rule_t;

  localparam int RULE_W = $bits(rule_t);

  // Outcome of testing one rule; at most one of exact, swc, iwc and call is set
  typedef struct packed {
    logic exact;
    logic plain;
    logic swc;
    logic iwc;
    logic call;
    logic iany;
  } hit_t;

  // Fold an upper-case letter to lower case on a 9-bit symbol
  function automatic logic [8:0] fold_lower(logic [8:0] c);
    logic [8:0] r;
    r = c;
    if (c >= {1'b0, CH_UPPER_A} && c <= {1'b0, CH_UPPER_Z}) begin
      r = c + FOLD_DELTA;
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/wildcard_rule_priority_matcher.sv =====
// ----------------------------------------------------------------------------
// wildcard_rule_priority_matcher
// Rule table with a sequential priority scan over state/input wildcards.
// ----------------------------------------------------------------------------
// A write item stores one rule in the rule table RAM and gives no result. A
// query item reads rules 0 to min(rule_count, RULE_DEPTH)-1 one per cycle
// through the RAM's registered read port; the scan stops early on the first
// plain exact hit. One item is worked on at a time, and in_stall is high from
// a query's transfer until its result is loaded into the output register,
// which holds it while out_stall is high. Table entries are undefined until
// written and need no clearing after reset.
// ----------------------------------------------------------------------------
module wildcard_rule_priority_matcher
  import wrpm_pkg::*;
#(
  parameter int RULE_DEPTH   = RULE_DEPTH_DEF,
  parameter int ACTION_WIDTH = ACTION_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int ADDR_W = (RULE_DEPTH > 1) ? $clog2(RULE_DEPTH) : 1;
  localparam int SCAN_W = $clog2(RULE_DEPTH + 1);
  localparam int AW_ST  = (ACTION_WIDTH < ACT_FIELD_W) ? ACTION_WIDTH : ACT_FIELD_W;
  localparam int WORD_W = RULE_W + AW_ST;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  // Control
  logic [1:0]        state_r, state_nxt;
  logic [SCAN_W-1:0] issue_r, issue_nxt;
  logic [SCAN_W-1:0] limit_r, limit_nxt;
  logic              rd_vld_r, rd_vld_nxt;
  logic [ADDR_W-1:0] rd_idx_r, rd_idx_nxt;

  // Configuration
  logic [7:0] input_base_r;
  logic [5:0] rule_count_r;

  // Query operands
  logic [7:0] qs_r, qs_nxt;
  logic [7:0] qi_r, qi_nxt;
  logic [8:0] qsum_r, qsum_nxt;

  // Candidates: exact, state wildcard, input wildcard, catch-all
  logic              ex_v_r, ex_v_nxt, sw_v_r, sw_v_nxt;
  logic              iw_v_r, iw_v_nxt, ca_v_r, ca_v_nxt;
  logic [ADDR_W-1:0] ex_idx_r, ex_idx_nxt, sw_idx_r, sw_idx_nxt;
  logic [ADDR_W-1:0] iw_idx_r, iw_idx_nxt, ca_idx_r, ca_idx_nxt;
  logic [AW_ST-1:0]  ex_act_r, ex_act_nxt, sw_act_r, sw_act_nxt;
  logic [AW_ST-1:0]  iw_act_r, iw_act_nxt, ca_act_r, ca_act_nxt;

  // Output register
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r, out_data_nxt;

  // RAM and evaluation
  logic              in_xfer;
  logic              ram_we;
  logic [WORD_W-1:0] ram_wdata;
  logic              ram_re;
  logic [WORD_W-1:0] ram_rdata;
  rule_t             rd_rule;
  logic [AW_ST-1:0]  rd_act;
  hit_t              hit;
  logic              last_rd;
  logic              stop;
  logic              out_free;
  rule_t             wr_rule;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || !out_stall;

  // Pack a rule write into a table word
  always_comb begin
    wr_rule.sval = in_data.state_value;
    wr_rule.sneg = in_data.state_negate;
    wr_rule.sany = in_data.state_any;
    wr_rule.ival = in_data.input_value;
    wr_rule.ineg = in_data.input_negate;
    wr_rule.cls  = in_data.class_mask;
    wr_rule.iany = in_data.input_any;
    wr_rule.fold = in_data.case_fold;
  end

  assign ram_wdata = {in_data.action_word[AW_ST-1:0], wr_rule};
  assign ram_we    = in_xfer && (in_data.action == ACT_WRITE)
                     && (32'(in_data.rule_index) < RULE_DEPTH);

  wrpm_ram #(
    .WIDTH (WORD_W),
    .DEPTH (RULE_DEPTH),
    .ADDR_W(ADDR_W)
  ) u_rule_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ADDR_W'(in_data.rule_index)),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(issue_r[ADDR_W-1:0]),
    .rdata(ram_rdata)
  );

  assign rd_rule = ram_rdata[RULE_W-1:0];
  assign rd_act  = ram_rdata[RULE_W +: AW_ST];

  wrpm_rule_eval u_eval (
    .rule(rd_rule),
    .qs  (qs_r),
    .qi  (qi_r),
    .qsum(qsum_r),
    .hit (hit)
  );

  // Scan end: plain exact hit or last rule returned
  assign last_rd = (SCAN_W'(rd_idx_r) + SCAN_W'(1)) == limit_r;
  assign stop    = (state_r == ST_SCAN) && rd_vld_r && ((hit.exact && hit.plain) || last_rd);
  assign ram_re  = (state_r == ST_SCAN) && (issue_r < limit_r) && !stop;

  // Sequencer, read issue and candidate update
  always_comb begin
    state_nxt  = state_r;
    issue_nxt  = issue_r;
    limit_nxt  = limit_r;
    rd_vld_nxt = ram_re;
    rd_idx_nxt = issue_r[ADDR_W-1:0];
    qs_nxt     = qs_r;
    qi_nxt     = qi_r;
    qsum_nxt   = qsum_r;
    ex_v_nxt   = ex_v_r;
    ex_idx_nxt = ex_idx_r;
    ex_act_nxt = ex_act_r;
    sw_v_nxt   = sw_v_r;
    sw_idx_nxt = sw_idx_r;
    sw_act_nxt = sw_act_r;
    iw_v_nxt   = iw_v_r;
    iw_idx_nxt = iw_idx_r;
    iw_act_nxt = iw_act_r;
    ca_v_nxt   = ca_v_r;
    ca_idx_nxt = ca_idx_r;
    ca_act_nxt = ca_act_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;

    if (ram_re) begin
      issue_nxt = issue_r + SCAN_W'(1);
    end

    case (state_r)
      ST_IDLE: begin
        // Latch a query and clear its candidates
        if (in_xfer && (in_data.action == ACT_QUERY)) begin
          qs_nxt    = in_data.state_value;
          qi_nxt    = in_data.input_value;
          qsum_nxt  = {1'b0, in_data.input_value} + {1'b0, input_base_r};
          issue_nxt = '0;
          if (32'(rule_count_r) > RULE_DEPTH) begin
            limit_nxt = SCAN_W'(RULE_DEPTH);
          end else begin
            limit_nxt = SCAN_W'(rule_count_r);
          end
          ex_v_nxt = 1'b0;
          sw_v_nxt = 1'b0;
          iw_v_nxt = 1'b0;
          ca_v_nxt = 1'b0;
          if (rule_count_r == 6'd0) begin
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        // Fold the returned rule into the candidates
        if (rd_vld_r) begin
          if (hit.exact) begin
            ex_v_nxt   = 1'b1;
            ex_idx_nxt = rd_idx_r;
            ex_act_nxt = rd_act;
          end else if (hit.swc) begin
            sw_v_nxt   = 1'b1;
            sw_idx_nxt = rd_idx_r;
            sw_act_nxt = rd_act;
          end else if (hit.iwc) begin
            if (!iw_v_r || !hit.iany) begin
              iw_v_nxt   = 1'b1;
              iw_idx_nxt = rd_idx_r;
              iw_act_nxt = rd_act;
            end
          end else if (hit.call) begin
            if (!ca_v_r || !hit.iany) begin
              ca_v_nxt   = 1'b1;
              ca_idx_nxt = rd_idx_r;
              ca_act_nxt = rd_act;
            end
          end
        end
        if (stop) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        // Pick by precedence and load the output register once it is free
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '0;
          if (ex_v_r) begin
            out_data_nxt.found         = 1'b1;
            out_data_nxt.result_action = ACT_FIELD_W'(ex_act_r);
            out_data_nxt.hit_index     = IDX_W'(ex_idx_r);
            out_data_nxt.match_kind    = KIND_EXACT;
          end else if (sw_v_r) begin
            out_data_nxt.found         = 1'b1;
            out_data_nxt.result_action = ACT_FIELD_W'(sw_act_r);
            out_data_nxt.hit_index     = IDX_W'(sw_idx_r);
            out_data_nxt.match_kind    = KIND_STATE_WC;
          end else if (iw_v_r) begin
            out_data_nxt.found         = 1'b1;
            out_data_nxt.result_action = ACT_FIELD_W'(iw_act_r);
            out_data_nxt.hit_index     = IDX_W'(iw_idx_r);
            out_data_nxt.match_kind    = KIND_INPUT_WC;
          end else if (ca_v_r) begin
            out_data_nxt.found         = 1'b1;
            out_data_nxt.result_action = ACT_FIELD_W'(ca_act_r);
            out_data_nxt.hit_index     = IDX_W'(ca_idx_r);
            out_data_nxt.match_kind    = KIND_CATCH_ALL;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
      ex_v_r      <= 1'b0;
      sw_v_r      <= 1'b0;
      iw_v_r      <= 1'b0;
      ca_v_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
      ex_v_r      <= ex_v_nxt;
      sw_v_r      <= sw_v_nxt;
      iw_v_r      <= iw_v_nxt;
      ca_v_r      <= ca_v_nxt;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      input_base_r <= '0;
      rule_count_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_INPUT_BASE: input_base_r <= cfg_data;
        CFG_RULE_COUNT: rule_count_r <= cfg_data[5:0];
        default: begin
          // drop writes to unknown registers
        end
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    issue_r    <= issue_nxt;
    limit_r    <= limit_nxt;
    rd_idx_r   <= rd_idx_nxt;
    qs_r       <= qs_nxt;
    qi_r       <= qi_nxt;
    qsum_r     <= qsum_nxt;
    ex_idx_r   <= ex_idx_nxt;
    ex_act_r   <= ex_act_nxt;
    sw_idx_r   <= sw_idx_nxt;
    sw_act_r   <= sw_act_nxt;
    iw_idx_r   <= iw_idx_nxt;
    iw_act_r   <= iw_act_nxt;
    ca_idx_r   <= ca_idx_nxt;
    ca_act_r   <= ca_act_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

// ===== rtl/core/wrpm_ram.sv =====
// ----------------------------------------------------------------------------
// wrpm_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module wrpm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/wrpm_rule_eval.sv =====
// ----------------------------------------------------------------------------
// wrpm_rule_eval
// Tests one stored rule against the query state and input and classifies
// the outcome as exact, state wildcard, input wildcard or catch-all.
// ----------------------------------------------------------------------------
module wrpm_rule_eval
  import wrpm_pkg::*;
(
  input  rule_t      rule,
  input  logic [7:0] qs,
  input  logic [7:0] qi,
  input  logic [8:0] qsum,
  output hit_t       hit
);

  logic sm;
  logic im_raw;
  logic im;
  logic sw;
  logic iw_raw;
  logic iw;

  // Per-rule state and input tests
  always_comb begin
    sm = (rule.sval == qs) != rule.sneg;
    if (rule.fold) begin
      im_raw = fold_lower({1'b0, rule.ival}) == fold_lower(qsum);
    end else begin
      im_raw = {1'b0, rule.ival} == qsum;
    end
    im = im_raw != rule.ineg;
    sw = rule.sany && !rule.sneg;

    // Class test on the raw query input
    iw_raw = (rule.cls[0] && (qi inside {[CH_LOWER_A:CH_LOWER_Z]}))
          || (rule.cls[1] && (qi inside {[CH_UPPER_A:CH_UPPER_Z]}))
          || (rule.cls[2] && (qi inside {[CH_DIGIT_0:CH_DIGIT_9]}))
          || (rule.cls[3] && (qi inside {[CH_TAB:CH_CR], CH_SPACE}))
          || (rule.iany && !rule.ineg && (rule.cls == 4'd0) && !rule.fold);
    if (rule.ineg && (rule.iany || (rule.cls != 4'd0))) begin
      iw = !iw_raw;
    end else begin
      iw = iw_raw;
    end
  end

  // Classify in precedence order
  always_comb begin
    hit      = '0;
    hit.iany = rule.iany;
    if (sm && im) begin
      hit.exact = 1'b1;
      hit.plain = !rule.sneg && !rule.ineg;
    end else if (sw && im) begin
      hit.swc = 1'b1;
    end else if (sm && iw) begin
      hit.iwc = 1'b1;
    end else if (sw && iw) begin
      hit.call = 1'b1;
    end
  end

endmodule

// ===== rtl/core/wrpm_checker.sv =====
// ----------------------------------------------------------------------------
// wrpm_checker
// Port-level checks on the wildcard rule priority matcher, bound to the top.
// ----------------------------------------------------------------------------
`include "wildcard_rule_priority_matcher_defines.svh"

module wrpm_checker
  import wrpm_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  // Hold a stalled result
  `WRPM_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed")

  // A miss reports all fields as zero
  `WRPM_ASSERT_SAME(a_miss_zero, out_valid && !out_data.found, (out_data.result_action == '0) && (out_data.hit_index == '0) && (out_data.match_kind == KIND_EXACT), "miss with non-zero fields")

  // A query transfer blocks the next item
  `WRPM_ASSERT_NEXT(a_query_busy, in_valid && !in_stall && (in_data.action == ACT_QUERY), in_stall, "no stall after query transfer")

  // A rule write taken while no result is held produces no result
  `WRPM_ASSERT_NEXT(a_write_silent, in_valid && !in_stall && (in_data.action == ACT_WRITE) && !out_valid, !out_valid, "result after rule write")

endmodule

bind wildcard_rule_priority_matcher wrpm_checker u_wrpm_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_stall (in_stall),
  .in_data  (in_data),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_data (out_data)
);

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: wildcard rule priority matcher testbench
// Drives rule writes and lookups through the valid/stall input channel and
// checks every lookup result against a fixed expected value on some directed
// rows, else against a predictor of the rule scan and its priorities. A short
// table of directed rows comes first, then random phases under several
// register settings and idling patterns.
module tb_top;
  import wrpm_pkg::*;

  localparam int SETTLE_CYCLES = 4;
  localparam int END_CYCLES    = RULE_DEPTH_DEF + 8;
  localparam int PHASES        = 6;
  localparam int PHASE_ITEMS   = 286;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

  typedef struct {
    logic                  is_cfg;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_val;
    in_item_t              item;
    logic                  typed;
    out_item_t             want;
  } stim_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Predictor state: rule table and register copies
  rule_t                  rule_store [RULE_DEPTH_DEF];
  logic [ACT_FIELD_W-1:0] act_store [RULE_DEPTH_DEF];
  logic [7:0]             cur_base = '0;
  logic [5:0]             cur_count = '0;

  out_item_t   pending_lookups [$];
  stim_row_t   stim_table [$];
  int          err_count = 0;
  int unsigned send_gap_pct = 0;
  int unsigned recv_stall_pct = 0;

  wildcard_rule_priority_matcher i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------- helpers

  function automatic logic [7:0] pick8(int unsigned lo, int unsigned hi);
    int unsigned v;
    v = $urandom_range(hi, lo);
    return v[7:0];
  endfunction

  function automatic logic chance(int unsigned pct);
    return $urandom_range(99) < pct;
  endfunction

  // Symbols biased towards the character classes and their edges
  function automatic logic [7:0] pick_sym();
    logic [7:0] s;
    case ($urandom_range(5))
      0: s = CH_LOWER_A + pick8(0, 25);
      1: s = CH_UPPER_A + pick8(0, 25);
      2: s = CH_DIGIT_0 + pick8(0, 9);
      3: s = chance(20) ? CH_SPACE : CH_TAB + pick8(0, 4);
      4: s = chance(50) ? 8'h00 : 8'hff;
      default: s = pick8(0, 255);
    endcase
    return s;
  endfunction

  function automatic logic [8:0] lower_sym(logic [8:0] c);
    if (c >= {1'b0, CH_UPPER_A} && c <= {1'b0, CH_UPPER_Z}) begin
      return c + FOLD_DELTA;
    end
    return c;
  endfunction

  function automatic logic class_test(rule_t r, logic [7:0] c);
    logic h;
    h = 1'b0;
    if (r.cls[0] && c >= CH_LOWER_A && c <= CH_LOWER_Z) h = 1'b1;
    if (r.cls[1] && c >= CH_UPPER_A && c <= CH_UPPER_Z) h = 1'b1;
    if (r.cls[2] && c >= CH_DIGIT_0 && c <= CH_DIGIT_9) h = 1'b1;
    if (r.cls[3] && ((c >= CH_TAB && c <= CH_CR) || c == CH_SPACE)) h = 1'b1;
    // bare input-any matches every symbol
    if (r.iany && !r.ineg && r.cls == 4'd0 && !r.fold) h = 1'b1;
    if (r.ineg && (r.iany || r.cls != 4'd0)) h = ~h;
    return h;
  endfunction

  // Scan the stored rules for one lookup and apply the priority order
  function automatic out_item_t predict_lookup(logic [7:0] qs, logic [7:0] qi);
    out_item_t res;
    rule_t     r;
    logic [8:0] qsum;
    logic [1:0] kind;
    logic stop, sm, im, sw, iw;
    int n, i, pick, exact_i, swc_i, iwc_i, call_i;
    qsum = {1'b0, qi} + {1'b0, cur_base};
    n = (cur_count > 6'd32) ? RULE_DEPTH_DEF : int'(cur_count);
    exact_i = -1;
    swc_i = -1;
    iwc_i = -1;
    call_i = -1;
    stop = 1'b0;
    for (i = 0; i < n; i++) begin
      if (!stop) begin
        r = rule_store[i];
        sm = (r.sval == qs) ^ r.sneg;
        if (r.fold) begin
          im = lower_sym({1'b0, r.ival}) == lower_sym(qsum);
        end else begin
          im = {1'b0, r.ival} == qsum;
        end
        im = im ^ r.ineg;
        sw = r.sany & ~r.sneg;
        iw = class_test(r, qi);
        if (sm && im) begin
          exact_i = i;
          // a plain exact hit ends the scan
          if (!r.sneg && !r.ineg) stop = 1'b1;
        end else if (sw && im) begin
          swc_i = i;
        end else if (sm && iw) begin
          if (iwc_i < 0 || !r.iany) iwc_i = i;
        end else if (sw && iw) begin
          if (call_i < 0 || !r.iany) call_i = i;
        end
      end
    end
    pick = -1;
    kind = KIND_EXACT;
    if (exact_i >= 0) begin
      pick = exact_i;
      kind = KIND_EXACT;
    end else if (swc_i >= 0) begin
      pick = swc_i;
      kind = KIND_STATE_WC;
    end else if (iwc_i >= 0) begin
      pick = iwc_i;
      kind = KIND_INPUT_WC;
    end else if (call_i >= 0) begin
      pick = call_i;
      kind = KIND_CATCH_ALL;
    end
    res = '0;
    if (pick >= 0) begin
      res.found = 1'b1;
      res.result_action = act_store[pick];
      res.hit_index = pick[4:0];
      res.match_kind = kind;
    end
    return res;
  endfunction

  function automatic in_item_t mk_rule(logic [4:0] idx, logic [7:0] sval, logic sneg,
                                       logic sany, logic [7:0] ival, logic ineg,
                                       logic [3:0] cls, logic iany, logic fold,
                                       logic [31:0] act);
    in_item_t it;
    it = '0;
    it.action = ACT_WRITE;
    it.rule_index = idx;
    it.state_value = sval;
    it.state_negate = sneg;
    it.state_any = sany;
    it.input_value = ival;
    it.input_negate = ineg;
    it.class_mask = cls;
    it.input_any = iany;
    it.case_fold = fold;
    it.action_word = act;
    return it;
  endfunction

  function automatic in_item_t mk_query(logic [7:0] qs, logic [7:0] qi);
    in_item_t it;
    it = '0;
    it.action = ACT_QUERY;
    it.state_value = qs;
    it.input_value = qi;
    return it;
  endfunction

  function automatic out_item_t mk_result(logic found, logic [31:0] act, logic [4:0] idx,
                                          logic [1:0] kind);
    out_item_t o;
    o.found = found;
    o.result_action = act;
    o.hit_index = idx;
    o.match_kind = kind;
    return o;
  endfunction

  // Random rule, flags mostly clear so that plain rules dominate
  function automatic in_item_t gen_rule();
    in_item_t it;
    logic [3:0] cls;
    logic [7:0] slot;
    int unsigned v;
    v = $urandom_range(15);
    cls = chance(35) ? v[3:0] : 4'd0;
    slot = pick8(0, 31);
    it = mk_rule(slot[4:0], chance(25) ? pick8(0, 255) : pick8(0, 3), chance(17),
                 chance(25), pick_sym(), chance(17), cls, chance(25), chance(25),
                 $urandom);
    return it;
  endfunction

  // Random lookup, mostly aimed at a stored rule within the scanned span
  function automatic in_item_t gen_query();
    in_item_t it;
    logic [63:0] junk;
    logic [7:0] sym;
    int span, j;
    span = (cur_count > 6'd32) ? RULE_DEPTH_DEF : int'(cur_count);
    junk = {$urandom, $urandom};
    it = junk[$bits(in_item_t)-1:0];
    it.action = ACT_QUERY;
    if (span > 0 && chance(60)) begin
      j = $urandom_range(span - 1);
      it.state_value = chance(25) ? pick8(0, 3) : rule_store[j].sval;
      sym = rule_store[j].ival;
      if (chance(35) && (lower_sym({1'b0, sym}) != {1'b0, sym} ||
          (sym >= CH_LOWER_A && sym <= CH_LOWER_Z))) begin
        sym = sym ^ 8'h20;
      end
      it.input_value = sym - cur_base;
    end else begin
      it.state_value = chance(20) ? pick8(0, 255) : pick8(0, 3);
      it.input_value = pick_sym();
    end
    return it;
  endfunction

  // --------------------------------------------------------------- checking

  task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
    err_count++;
    $display("[%0t] mismatch %s: got %h, want %h", $realtime, what, got, want);
  endtask

  // Compare each result transfer with the oldest pending lookup
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_lookups.size() == 0) begin
        flag_mismatch("unexpected result", 32'(out_data.found), 32'd0);
      end else begin
        want = pending_lookups.pop_front();
        if (out_data.found !== want.found)
          flag_mismatch("found", 32'(out_data.found), 32'(want.found));
        if (out_data.result_action !== want.result_action)
          flag_mismatch("result_action", out_data.result_action, want.result_action);
        if (out_data.hit_index !== want.hit_index)
          flag_mismatch("hit_index", 32'(out_data.hit_index), 32'(want.hit_index));
        if (out_data.match_kind !== want.match_kind)
          flag_mismatch("match_kind", 32'(out_data.match_kind), 32'(want.match_kind));
      end
    end
  end

  // Random back-pressure on the result channel
  always @(posedge clk) begin
    out_stall <= chance(recv_stall_pct);
  end

  // ---------------------------------------------------------------- driving

  // Drop valid and hold until every lookup has returned
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_lookups.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic push_item(in_item_t it, logic typed, out_item_t want);
    while (chance(send_gap_pct)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    // transfer taken: update the table copy or queue the lookup result
    if (it.action == ACT_WRITE) begin
      rule_store[it.rule_index] = '{it.state_value, it.state_negate, it.state_any,
                                    it.input_value, it.input_negate, it.class_mask,
                                    it.input_any, it.case_fold};
      act_store[it.rule_index] = it.action_word;
    end else begin
      pending_lookups.push_back(typed ? want
                                      : predict_lookup(it.state_value, it.input_value));
    end
  endtask

  task automatic cfg_put(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_INPUT_BASE) cur_base = val;
    else if (idx == CFG_RULE_COUNT) cur_count = val[5:0];
  endtask

  task automatic row_item(in_item_t it);
    stim_table.push_back('{1'b0, '0, '0, it, 1'b0, '0});
  endtask

  task automatic row_check(in_item_t it, out_item_t want);
    stim_table.push_back('{1'b0, '0, '0, it, 1'b1, want});
  endtask

  task automatic row_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    stim_table.push_back('{1'b1, idx, val, '0, 1'b0, '0});
  endtask

  // Give up after a generous bound
  initial begin
    #5000000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    in_item_t all_ones;
    in_item_t it;
    int p, k;

    // Directed rows: empty table, one rule of each flavour, register edges
    all_ones = '1;
    row_check(mk_query(8'h00, 8'h00), mk_result(1'b0, 32'd0, 5'd0, KIND_EXACT));
    row_check(all_ones, mk_result(1'b0, 32'd0, 5'd0, KIND_EXACT));
    row_item(mk_rule(5'd0, 8'h10, 1'b0, 1'b0, CH_LOWER_A, 1'b0, 4'h0, 1'b0, 1'b0,
                     32'hffff_ffff));
    row_item(mk_rule(5'd1, 8'h10, 1'b1, 1'b0, 8'h62, 1'b0, 4'h0, 1'b0, 1'b0,
                     32'h0000_0001));
    row_item(mk_rule(5'd2, 8'h77, 1'b0, 1'b1, CH_UPPER_A, 1'b0, 4'h0, 1'b0, 1'b1,
                     32'ha5a5_5a5a));
    row_item(mk_rule(5'd3, 8'h20, 1'b0, 1'b0, 8'h00, 1'b0, 4'b0100, 1'b0, 1'b0,
                     32'h0000_0000));
    row_item(mk_rule(5'd4, 8'h20, 1'b0, 1'b0, 8'h00, 1'b1, 4'b1000, 1'b0, 1'b0,
                     32'h0000_4444));
    row_item(mk_rule(5'd5, 8'h00, 1'b0, 1'b1, 8'h00, 1'b0, 4'h0, 1'b1, 1'b0,
                     32'h1234_5678));
    row_item(mk_rule(5'd31, 8'hff, 1'b1, 1'b1, 8'hff, 1'b1, 4'hf, 1'b1, 1'b1,
                     32'hffff_ffff));
    row_cfg(CFG_RULE_COUNT, 8'd6);
    row_check(mk_query(8'h10, CH_LOWER_A),
              mk_result(1'b1, 32'hffff_ffff, 5'd0, KIND_EXACT));
    row_item(mk_query(8'h10, 8'h62));
    row_item(mk_query(8'h11, 8'h62));
    row_item(mk_query(8'h00, CH_UPPER_A));
    row_item(mk_query(8'h00, CH_LOWER_A));
    row_item(mk_query(8'h20, 8'h35));
    row_item(mk_query(8'h20, CH_SPACE));
    row_item(mk_query(8'h20, CH_UPPER_A));
    row_item(mk_query(8'h55, CH_TAB));
    // a 9-bit sum must not wrap back onto rule 0
    row_cfg(CFG_INPUT_BASE, 8'he2);
    row_item(mk_query(8'h10, 8'h7f));
    row_cfg(CFG_INPUT_BASE, 8'hff);
    row_item(mk_query(8'h10, 8'hff));
    row_cfg(CFG_SPARE_2, 8'hff);
    row_cfg(CFG_SPARE_3, 8'h00);
    row_item(mk_query(8'h10, 8'h62));
    row_cfg(CFG_INPUT_BASE, 8'h00);
    row_cfg(CFG_RULE_COUNT, 8'hc6);
    row_item(mk_query(8'h11, 8'h62));

    // Hold reset, then walk the table
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (stim_table[r]) begin
      if (stim_table[r].is_cfg) begin
        cfg_put(stim_table[r].cfg_idx, stim_table[r].cfg_val);
      end else begin
        push_item(stim_table[r].item, stim_table[r].typed, stim_table[r].want);
      end
    end

    // Fill every slot before any wider scan
    for (k = 0; k < RULE_DEPTH_DEF; k++) begin
      it = gen_rule();
      it.rule_index = k[4:0];
      push_item(it, 1'b0, '0);
    end

    // Random phases under varied settings and idling patterns
    for (p = 0; p < PHASES; p++) begin
      if (p < 2) begin
        send_gap_pct = 15;
        recv_stall_pct = 74;
      end else if (p < 4) begin
        send_gap_pct = 74;
        recv_stall_pct = 15;
      end else begin
        send_gap_pct = 0;
        recv_stall_pct = 0;
      end
      case (p)
        0: begin
          cfg_put(CFG_INPUT_BASE, 8'd0);
          cfg_put(CFG_RULE_COUNT, 8'd32);
        end
        1: begin
          cfg_put(CFG_INPUT_BASE, 8'd255);
          cfg_put(CFG_RULE_COUNT, 8'd1);
        end
        2: begin
          cfg_put(CFG_INPUT_BASE, pick8(0, 255));
          cfg_put(CFG_RULE_COUNT, 8'd63);
        end
        3: begin
          cfg_put(CFG_INPUT_BASE, pick8(0, 255));
          cfg_put(CFG_RULE_COUNT, pick8(0, 32));
        end
        4: begin
          cfg_put(CFG_INPUT_BASE, 8'd0);
          cfg_put(CFG_RULE_COUNT, 8'd32);
        end
        default: begin
          cfg_put(CFG_INPUT_BASE, pick8(0, 8));
          cfg_put(CFG_RULE_COUNT, pick8(1, 32));
        end
      endcase
      for (k = 0; k < PHASE_ITEMS; k++) begin
        // hold the sender once until all lookups are back
        if (p == 2 && k == 100) wait_idle();
        if (chance(25)) push_item(gen_rule(), 1'b0, '0);
        else push_item(gen_query(), 1'b0, '0);
      end
    end

    wait_idle();
    repeat (END_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/wrpm_pkg.sv
rtl/core/wrpm_ram.sv
rtl/core/wrpm_rule_eval.sv
rtl/core/wildcard_rule_priority_matcher.sv
rtl/core/wrpm_checker.sv
tb/tb_top.sv
